>>> rtl/tisf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tisf_pkg
// Shared types, telnet byte codes and reply byte tables for the IAC filter.
// ----------------------------------------------------------------------------
package tisf_pkg;

   // telnet command and option bytes
   localparam logic [7:0] B_IAC        = 8'hFF;
   localparam logic [7:0] B_SB         = 8'hFA;
   localparam logic [7:0] B_DONT       = 8'hFE;
   localparam logic [7:0] B_DO         = 8'hFD;
   localparam logic [7:0] B_WONT       = 8'hFC;
   localparam logic [7:0] B_WILL       = 8'hFB;
   localparam logic [7:0] B_SE         = 8'hF0;
   localparam logic [7:0] B_NUL        = 8'h00;
   localparam logic [7:0] OPT_NAWS     = 8'h1F;
   localparam logic [7:0] OPT_TTYPE    = 8'h18;
   localparam logic [7:0] OPT_COMPRESS = 8'h54;

   // terminal type string
   localparam logic [7:0] TERM_C0 = 8'h78; // x
   localparam logic [7:0] TERM_C1 = 8'h74; // t
   localparam logic [7:0] TERM_C2 = 8'h65; // e
   localparam logic [7:0] TERM_C3 = 8'h72; // r
   localparam logic [7:0] TERM_C4 = 8'h6D; // m

   // register indexes on the csr port
   localparam int          CSR_ADDR_W    = 4;
   localparam logic [1:0]  REG_COMP_ALLOW = 2'd0;
   localparam logic [1:0]  REG_COLUMNS    = 2'd1;
   localparam logic [1:0]  REG_ROWS       = 2'd2;

   localparam logic [15:0] COLUMNS_RESET = 16'd80;
   localparam logic [15:0] ROWS_RESET    = 16'd24;

   // job queue between parser and sequencer
   localparam int JOBQ_DEPTH = 4;
   localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
   localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

   // byte index within one reply run (longest run is 12 bytes)
   localparam int IDX_W = 4;

   typedef enum logic [7:0] {
      ST_STREAM = 8'b0000_0001,
      ST_IAC    = 8'b0000_0010,
      ST_DO     = 8'b0000_0100,
      ST_DONT   = 8'b0000_1000,
      ST_WILL   = 8'b0001_0000,
      ST_WONT   = 8'b0010_0000,
      ST_SB     = 8'b0100_0000,
      ST_SB_IAC = 8'b1000_0000
   } parser_state_type;

   typedef enum logic [1:0] {
      JOB_DATA  = 2'd0,   // one data byte to the terminal
      JOB_REPLY = 2'd1,   // IAC cmd opt
      JOB_NAWS  = 2'd2,   // WILL NAWS plus window-size report
      JOB_TTYPE = 2'd3    // terminal-type subnegotiation reply
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   cmd;
      logic [7:0]   opt;     // data byte for JOB_DATA
      logic         comp_on; // compression flag after this request
   } job_type;

   function automatic logic [IDX_W-1:0] job_last(input job_kind_type kind);
      logic [IDX_W-1:0] r;
      case (kind)
         JOB_DATA:  r = IDX_W'(0);
         JOB_REPLY: r = IDX_W'(2);
         JOB_NAWS:  r = IDX_W'(11);
         JOB_TTYPE: r = IDX_W'(10);
         default:   r = IDX_W'(0);
      endcase
      return r;
   endfunction

   function automatic logic [7:0] job_byte(input job_type job, input logic [IDX_W-1:0] idx,
                                            input logic [15:0] cols,
                                            input logic [15:0] rows);
      logic [7:0] r;
      r = B_NUL;
      case (job.kind)
         JOB_DATA: r = job.opt;
         JOB_REPLY: begin
            case (idx)
               4'd0:    r = B_IAC;
               4'd1:    r = job.cmd;
               default: r = job.opt;
            endcase
         end
         JOB_NAWS: begin
            case (idx)
               4'd0:    r = B_IAC;
               4'd1:    r = B_WILL;
               4'd2:    r = OPT_NAWS;
               4'd3:    r = B_IAC;
               4'd4:    r = B_SB;
               4'd5:    r = OPT_NAWS;
               4'd6:    r = cols[15:8];
               4'd7:    r = cols[7:0];
               4'd8:    r = rows[15:8];
               4'd9:    r = rows[7:0];
               4'd10:   r = B_IAC;
               default: r = B_SE;
            endcase
         end
         JOB_TTYPE: begin
            case (idx)
               4'd0:    r = B_IAC;
               4'd1:    r = B_SB;
               4'd2:    r = OPT_TTYPE;
               4'd3:    r = B_NUL;
               4'd4:    r = TERM_C0;
               4'd5:    r = TERM_C1;
               4'd6:    r = TERM_C2;
               4'd7:    r = TERM_C3;
               4'd8:    r = TERM_C4;
               4'd9:    r = B_IAC;
               default: r = B_SE;
            endcase
         end
         default: r = B_NUL;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/telnet_iac_stream_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_iac_stream_filter
// Telnet receive filter: forwards data bytes and answers option requests.
// ----------------------------------------------------------------------------
// Received server bytes enter on the req_ channel, one byte per request.
// Every result leaves on the rsp_ channel: destination 0 is a data byte for
// the terminal, destination 1 a reply byte for the server; last_of_run marks
// the final result of one request and compression_on the flag after it.
// Requests that cause nothing (NUL, command prefixes, dropped bytes) produce
// no response.
// The parser classifies a request in the cycle it is accepted and queues one
// job (four deep); the sequencer emits one result byte per cycle from the
// head job unless rsp_stall holds it; a job passes the queue and then the
// response register. Unstalled, data runs at one request per cycle. A request
// holds the sequencer for all its results (3 for a short reply, 11 for terminal
// type, 12 for window size); the parser keeps accepting until the queue fills.
// While rsp_stall is high a valid response register holds its value and the
// queue absorbs further requests; req_stall rises when the queue is full.
// Reset puts the parser in stream state, clears the compression flag and
// loads the registers with their defaults (80 columns, 24 rows).
// ----------------------------------------------------------------------------
module telnet_iac_stream_filter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_destination,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_last_of_run,
   output logic                            rsp_compression_on,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tisf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import tisf_pkg::*;

   logic        comp_allow_ff;
   logic [15:0] columns_ff;
   logic [15:0] rows_ff;
   logic        csr_write;
   logic [1:0]  reg_sel;

   logic        q_full;
   logic        push;
   job_type     push_job;
   logic        pop;
   logic        head_valid;
   job_type     head_job;

   assign pready    = 1'b1;
   assign reg_sel   = paddr[3:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         comp_allow_ff <= 1'b0;
         columns_ff    <= COLUMNS_RESET;
         rows_ff       <= ROWS_RESET;
      end else if (csr_write) begin
         case (reg_sel)
            REG_COMP_ALLOW: comp_allow_ff <= pwdata[0];
            REG_COLUMNS:    columns_ff    <= pwdata[15:0];
            REG_ROWS:       rows_ff       <= pwdata[15:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_COMP_ALLOW: prdata = {31'd0, comp_allow_ff};
         REG_COLUMNS:    prdata = {16'd0, columns_ff};
         REG_ROWS:       prdata = {16'd0, rows_ff};
         default:        prdata = 32'd0;
      endcase
   end

   assign req_stall = q_full;

   tisf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_rx_byte  (req_rx_byte),
      .q_full       (q_full),
      .comp_allowed (comp_allow_ff),
      .push         (push),
      .push_job     (push_job)
   );

   tisf_jobq u_jobq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   tisf_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_job           (head_job),
      .columns            (columns_ff),
      .rows               (rows_ff),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_destination    (rsp_destination),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_compression_on (rsp_compression_on)
   );

endmodule

>>> rtl/tisf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tisf_front
// Telnet parser: accepts received bytes, tracks command state and turns each
// byte into at most one output job for the sequencer.
// ----------------------------------------------------------------------------
module tisf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [7:0]       req_rx_byte,
   input  logic             q_full,
   input  logic             comp_allowed,
   output logic             push,
   output tisf_pkg::job_type push_job
);
   import tisf_pkg::*;

   parser_state_type state_ff, state_in;
   logic             comp_ff, comp_in;
   logic             accept;
   logic             has_job;
   job_kind_type     kind;
   logic [7:0]       cmd;
   logic [7:0]       c;

   assign accept = req_valid && !q_full;
   assign c      = req_rx_byte;

   always_comb begin
      state_in = ST_STREAM;
      comp_in  = comp_ff;
      has_job  = 1'b0;
      kind     = JOB_DATA;
      cmd      = B_NUL;
      case (state_ff)
         ST_STREAM: begin
            if (c == B_IAC) begin
               state_in = ST_IAC;
            end else if (c != B_NUL) begin
               has_job = 1'b1;
            end
         end
         ST_IAC: begin
            if (c == B_IAC) begin
               has_job = 1'b1;   // escaped 0xFF data byte
            end else if (c == B_SB) begin
               state_in = ST_SB;
            end else if (c == B_DONT) begin
               state_in = ST_DONT;
            end else if (c == B_DO) begin
               state_in = ST_DO;
            end else if (c == B_WONT) begin
               state_in = ST_WONT;
            end else if (c == B_WILL) begin
               state_in = ST_WILL;
            end
         end
         ST_SB: begin
            state_in = ST_SB;
            if (c == B_IAC) begin
               state_in = ST_SB_IAC;
            end else if (c == OPT_TTYPE) begin
               has_job = 1'b1;
               kind    = JOB_TTYPE;
            end else if (c == OPT_COMPRESS) begin
               comp_in = 1'b1;
            end
         end
         ST_SB_IAC: begin
            state_in = (c == B_SE) ? ST_STREAM : ST_SB;
         end
         ST_WILL: begin
            if (c == OPT_COMPRESS && comp_allowed) begin
               has_job = 1'b1;
               kind    = JOB_REPLY;
               cmd     = B_DO;
            end
         end
         ST_DO: begin
            has_job = 1'b1;
            if (c == OPT_NAWS) begin
               kind = JOB_NAWS;
            end else if (c == OPT_TTYPE) begin
               kind = JOB_REPLY;
               cmd  = B_WILL;
            end else begin
               kind = JOB_REPLY;
               cmd  = B_WONT;
            end
         end
         default: state_in = ST_STREAM; // DONT, WONT: option byte dropped
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_STREAM;
         comp_ff  <= 1'b0;
      end else if (accept) begin
         state_ff <= state_in;
         comp_ff  <= comp_in;
      end
   end

   assign push             = accept && has_job;
   assign push_job.kind    = kind;
   assign push_job.cmd     = cmd;
   assign push_job.opt     = c;
   assign push_job.comp_on = comp_in;

   a_comp_sticky: assert property (@(posedge clock) disable iff (reset)
      comp_ff |=> comp_ff)
      else $error("compression flag cleared");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push)
      else $error("job pushed into full queue");

   a_iac_from_stream: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IAC) |-> $past(state_ff == ST_STREAM || state_ff == ST_IAC))
      else $error("IAC state entered from unexpected state");

endmodule

>>> rtl/tisf_jobq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tisf_jobq
// Small register FIFO of jobs between the parser and the byte sequencer.
// ----------------------------------------------------------------------------
module tisf_jobq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tisf_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output tisf_pkg::job_type head_job
);
   import tisf_pkg::*;

   job_type                 mem_ff [JOBQ_DEPTH];
   logic [JOBQ_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [JOBQ_CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == JOBQ_CNT_W'(JOBQ_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty job queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= JOBQ_CNT_W'(JOBQ_DEPTH))
      else $error("job queue count overflow");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("job queue pointers disagree with count");

endmodule

>>> rtl/tisf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tisf_back
// Byte sequencer: walks the head job one byte per cycle into the response
// register unless rsp_stall holds it, and pops the job as its last byte loads.
// ----------------------------------------------------------------------------
module tisf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  tisf_pkg::job_type head_job,
   input  logic [15:0]       columns,
   input  logic [15:0]       rows,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_destination,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last_of_run,
   output logic              rsp_compression_on
);
   import tisf_pkg::*;

   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] last_idx;
   logic             out_load;
   logic             at_last;
   logic             valid_ff;
   logic             dest_ff;
   logic [7:0]       byte_ff;
   logic             last_ff;
   logic             comp_ff;

   assign last_idx = job_last(head_job.kind);
   assign at_last  = (idx_ff == last_idx);
   assign out_load = head_valid && (!valid_ff || !rsp_stall);
   assign pop      = out_load && at_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            idx_ff   <= at_last ? '0 : idx_ff + 1'b1;
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         dest_ff <= (head_job.kind != JOB_DATA);
         byte_ff <= job_byte(head_job, idx_ff, columns, rows);
         last_ff <= at_last;
         comp_ff <= head_job.comp_on;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_destination    = dest_ff;
   assign rsp_out_byte       = byte_ff;
   assign rsp_last_of_run    = last_ff;
   assign rsp_compression_on = comp_ff;

   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (idx_ff <= last_idx))
      else $error("byte index past end of run");

   a_idx_wraps: assert property (@(posedge clock) disable iff (reset)
      pop |=> (idx_ff == '0))
      else $error("byte index not cleared after run");

   a_data_single: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !dest_ff) |-> last_ff)
      else $error("data byte not marked last of run");

endmodule
